// File: src/note_to_pitch_converter_unit_macros.svh
// assertion macros for the note to pitch converter
// no dependencies; included by the top level only
`ifndef NOTE_TO_PITCH_CONVERTER_UNIT_MACROS_SVH
`define NOTE_TO_PITCH_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked every cycle outside reset
`define NPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: src/npc_pkg.sv
// shared types and constants for the note to pitch converter
// no dependencies
`default_nettype none

package npc_pkg;

  localparam int unsigned NoteW    = 7;
  localparam int unsigned PosW     = 14;
  localparam int unsigned OctW     = 4;
  localparam int unsigned ResidW   = 11;
  localparam int unsigned BaseW    = 16;
  localparam int unsigned StepsW   = 6;
  localparam int unsigned PartW    = 5;
  localparam int unsigned RatioW   = 14;
  localparam int unsigned AccW     = 29;
  localparam int unsigned PitchW   = 14;
  localparam int unsigned MaxOct   = 10;

  localparam logic [ResidW-1:0] OCTAVE_UNITS = 11'd1536;
  localparam logic [BaseW-1:0]  UNITY_BASE   = 16'h1000;
  localparam logic [RatioW-1:0] UNITY_RATIO  = 14'h1000;
  localparam logic [RatioW-1:0] STEP_RATIO   = 14'h103B;
  localparam logic [PitchW-1:0] PITCH_MAX    = 14'h3FFF;

  // classified work item passed from front to back
  typedef struct packed {
    logic [BaseW-1:0]  shifted;
    logic [StepsW-1:0] nsteps;
    logic [PartW-1:0]  part;
  } job_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic load;
  } back_stat_t;

  // k octaves expressed in 1/128 semitone units
  function automatic logic [PosW-1:0] oct_span(input logic [OctW-1:0] k);
    logic [PosW-1:0] r;
    r = PosW'(k) * PosW'(OCTAVE_UNITS);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/note_to_pitch_converter_unit.sv
// note to pitch converter: top level joining front end, queue and back end
// depends on npc_pkg, npc_front, npc_queue, npc_back and the macros header
//
// usage
//   input channel in_valid/in_ready carries a centre note and fine tune and a
//   target note and fine tune; each transfer yields exactly one pitch_value
//   on the out_valid/out_ready channel, 0x1000 meaning unity, max 0x3FFF
//   the front end classifies the note distance in the transfer cycle and
//   pushes it into a two-entry queue; in_ready is low only while it is full
//   the back end pops one job, runs one ratio multiply per cycle for
//   (remainder >> 5) steps (0 to 47), then forms the lo product, the hi
//   product and the interpolation in turn
//   the back end takes a new job only once the last result has been loaded
//   into the output register, so the rate is set by the ratio step loop
//   and the product and interpolation states of the back end
//   a stalled receiver holds the result in the output register; the back end
//   finishes the next job and waits, and the queue keeps taking input until
//   full
//   synchronous reset empties the queue, idles the back end, drops out_valid
`default_nettype none
`include "note_to_pitch_converter_unit_macros.svh"

module note_to_pitch_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [6:0]  in_center_note,
  input  wire logic [6:0]  in_center_fine,
  input  wire logic [6:0]  in_target_note,
  input  wire logic [6:0]  in_target_fine,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_pitch_value
);
  import npc_pkg::*;

  // front to queue
  logic       push_valid, push_ready;
  job_t       push_data;
  // queue to back
  logic       pop_valid, pop_ready;
  job_t       pop_data;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  npc_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_center_note (in_center_note),
    .in_center_fine (in_center_fine),
    .in_target_note (in_target_note),
    .in_target_fine (in_target_fine),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  npc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .stat       (q_stat)
  );

  npc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pitch_value (out_pitch_value),
    .stat            (b_stat)
  );

  // queue occupancy never exceeds its two entries
  `NPC_ASSERT_ALWAYS(a_q_count, clk, rst_n, q_stat.count != 2'd3, "queue overflow")
  // back end only takes a job when one is queued
  `NPC_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop_ready && !b_stat.busy && pop_valid, !q_stat.empty, "pop from empty queue")
  // a new result appears only after the back end loaded it
  `NPC_ASSERT_NOW(a_out_from_load, clk, rst_n, $rose(out_valid), $past(b_stat.load), "result without load")

endmodule

`default_nettype wire

// File: src/npc_queue.sv
// two-entry queue carrying classified jobs from front to back
// depends on npc_pkg
`default_nettype none

module npc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire npc_pkg::job_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output npc_pkg::job_t      pop_data,
  output npc_pkg::q_stat_t   stat
);
  import npc_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign stat.count = count_r;
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/npc_front.sv
// front end: splits the note distance into octave base, ratio steps and fraction
// depends on npc_pkg
`default_nettype none

module npc_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [6:0]    in_center_note,
  input  wire logic [6:0]    in_center_fine,
  input  wire logic [6:0]    in_target_note,
  input  wire logic [6:0]    in_target_fine,
  output logic               push_valid,
  input  wire logic          push_ready,
  output npc_pkg::job_t      push_data
);
  import npc_pkg::*;

  logic [PosW-1:0]   c_pos, t_pos, mag;
  logic              upward;
  logic [OctW-1:0]   octs, octs_dn;
  logic [ResidW-1:0] resid, resid_dn;
  logic [PosW-1:0]   rem_full;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    c_pos  = {in_center_note, in_center_fine};
    t_pos  = {in_target_note, in_target_fine};
    upward = (t_pos >= c_pos);
    mag    = upward ? (t_pos - c_pos) : (c_pos - t_pos);

    // octave count from independent threshold compares
    octs = '0;
    for (int k = 1; k <= MaxOct; k++) begin
      if (mag >= oct_span(OctW'(k))) begin
        octs = OctW'(k);
      end
    end
    rem_full = mag - oct_span(octs);
    resid    = rem_full[ResidW-1:0];

    // downward with a remainder borrows one octave
    octs_dn  = octs;
    resid_dn = resid;
    if (resid != '0) begin
      octs_dn  = octs + OctW'(1);
      resid_dn = OCTAVE_UNITS - resid;
    end

    if (upward) begin
      push_data.shifted = UNITY_BASE << octs;
      push_data.nsteps  = resid[ResidW-1:PartW];
      push_data.part    = resid[PartW-1:0];
    end else begin
      push_data.shifted = UNITY_BASE >> octs_dn;
      push_data.nsteps  = resid_dn[ResidW-1:PartW];
      push_data.part    = resid_dn[PartW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/npc_back.sv
// back end: iterated ratio steps, interpolation, saturation and output register
// depends on npc_pkg
`default_nettype none

module npc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire npc_pkg::job_t pop_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [13:0]        out_pitch_value,
  output npc_pkg::back_stat_t stat
);
  import npc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_STEP = 6'b000010,
    ST_MLO  = 6'b000100,
    ST_MHI  = 6'b001000,
    ST_MIX  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [StepsW-1:0] cnt_r;
  logic [RatioW-1:0] m_prev_r, m_r;
  logic [BaseW-1:0]  shifted_r;
  logic [PartW-1:0]  part_r;
  logic [AccW-1:0]   lo_r, hi_r, sum_r;
  logic              out_valid_r, out_valid_nxt;
  logic [PitchW-1:0] out_pitch_r;

  logic [RatioW+RatioW-1:0] step_prod;
  logic [AccW-1:0]          diff;
  logic [AccW-1:0]          term;
  logic [AccW-12-1:0]       scaled;
  logic                     load;

  assign pop_ready       = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pitch_value = out_pitch_r;
  assign load            = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign stat.busy       = (state_r != ST_IDLE);
  assign stat.load       = load;

  assign step_prod = m_r * STEP_RATIO;
  assign diff      = hi_r - lo_r;
  assign term      = AccW'(diff[AccW-1:PartW] * part_r);
  assign scaled    = sum_r[AccW-1:12];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_STEP;
      ST_STEP: if (cnt_r == '0) state_nxt = ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_DONE;
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        shifted_r <= pop_data.shifted;
        cnt_r     <= pop_data.nsteps;
        part_r    <= pop_data.part;
        m_prev_r  <= UNITY_RATIO;
        m_r       <= STEP_RATIO;
      end
      ST_STEP: begin
        if (cnt_r != '0) begin
          m_prev_r <= m_r;
          m_r      <= step_prod[RatioW+12-1:12];
          cnt_r    <= cnt_r - StepsW'(1);
        end
      end
      ST_MLO:  lo_r  <= AccW'(shifted_r) * AccW'(m_prev_r);
      ST_MHI:  hi_r  <= AccW'(shifted_r) * AccW'(m_r);
      ST_MIX:  sum_r <= lo_r + term;
      default: ;
    endcase
    if (load) begin
      out_pitch_r <= (scaled > {3'b000, PITCH_MAX}) ? PITCH_MAX : scaled[PitchW-1:0];
    end
  end

endmodule

`default_nettype wire
